@@ sv/fsss_pkg.sv @@
// ----------------------------------------------------------------------------
// fsss_pkg
// Shared types and constants for the scoped frame slot stack.
// ----------------------------------------------------------------------------
package fsss_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int OFFSET_BITS_DEF = 16;
   localparam int SLOT_W          = 16;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POP   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      STATUS_DONE   = 3'd0,
      STATUS_OBJECT = 3'd1,
      STATUS_MARKER = 3'd2,
      STATUS_FULL   = 3'd3,
      STATUS_EMPTY  = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [SLOT_W-1:0]   slot_size;
      logic                is_object;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot_offset;
   } rsp_type;

endpackage

@@ sv/fsss_mem.sv @@
// ----------------------------------------------------------------------------
// fsss_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fsss_mem #(
   parameter int DEPTH   = 64,
   parameter int ENTRY_W = 34
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [ENTRY_W-1:0]       rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fsss_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsss_ctrl
// Request sequencer: push, allocate and the pop walk over the entry store.
// ----------------------------------------------------------------------------
module fsss_ctrl #(
   parameter int STACK_DEPTH = 64,
   parameter int OFFSET_BITS = 16,
   parameter int ENTRY_W     = 34
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fsss_pkg::req_type              req_payload,
   output logic                           res_valid,
   output fsss_pkg::rsp_type              res_payload,
   input  logic                           res_take,
   output logic                           wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   output logic [ENTRY_W-1:0]             wr_data,
   output logic                           rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   input  logic [ENTRY_W-1:0]             rd_data
);

   import fsss_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int SUM_W  = ((OFFSET_BITS > SLOT_W) ? OFFSET_BITS : SLOT_W) + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_RESULT
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   base_ff, base_in;
   logic                   rd_zero_ff, rd_zero_in;
   rsp_type                res_ff, res_in;

   logic [CNT_W-1:0]       top_idx;
   logic                   full;
   logic [SUM_W-1:0]       sum;
   logic                   ovf;
   logic [SLOT_W-1:0]      e_size;
   logic [OFFSET_BITS-1:0] e_start;
   logic                   e_obj;
   logic                   e_marker;

   assign top_idx  = count_ff - CNT_W'(1);
   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign sum      = SUM_W'(offset_ff) + SUM_W'(req_payload.slot_size);
   assign ovf      = |sum[SUM_W-1:OFFSET_BITS];
   assign e_size   = rd_data[ENTRY_W-1 -: SLOT_W];
   assign e_start  = rd_data[OFFSET_BITS+1:2];
   assign e_obj    = rd_data[1];
   assign e_marker = rd_data[0] | (rd_zero_ff & base_ff);

   assign req_stall   = (state_ff != S_IDLE);
   assign res_valid   = (state_ff == S_RESULT);
   assign res_payload = res_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      base_in   = base_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[ADDR_W-1:0];
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = top_idx[ADDR_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RESULT;
               res_in   = '{status: STATUS_DONE, slot_offset: '0};
               case (req_payload.opcode)
                  OP_ALLOC: begin
                     if (full || ovf) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_data   = {req_payload.slot_size, offset_ff,
                                     req_payload.is_object, 1'b0};
                        count_in  = count_ff + CNT_W'(1);
                        offset_in = sum[OFFSET_BITS-1:0];
                        res_in.slot_offset = SLOT_W'(offset_ff);
                        if (count_ff == '0) begin
                           base_in = 1'b0;
                        end
                     end
                  end
                  OP_PUSH: begin
                     if (full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = {{(ENTRY_W-1){1'b0}}, 1'b1};
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == '0) begin
                           base_in = 1'b0;
                        end
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            count_in = top_idx;
            if (e_marker) begin
               res_in   = '{status: STATUS_MARKER, slot_offset: '0};
               state_in = S_RESULT;
            end else begin
               offset_in = offset_ff - OFFSET_BITS'(e_size);
               if (e_obj) begin
                  res_in   = '{status: STATUS_OBJECT, slot_offset: SLOT_W'(e_start)};
                  state_in = S_RESULT;
               end else if (top_idx == '0) begin
                  res_in   = '{status: STATUS_EMPTY, slot_offset: '0};
                  state_in = S_RESULT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(top_idx - CNT_W'(1));
               end
            end
         end
         S_RESULT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rd_zero_in = rd_en ? (rd_addr == '0) : rd_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= CNT_W'(1);
         offset_ff  <= '0;
         base_ff    <= 1'b1;
         rd_zero_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         offset_ff  <= offset_in;
         base_ff    <= base_in;
         rd_zero_ff <= rd_zero_in;
      end
      res_ff <= res_in;
   end

endmodule

@@ sv/scoped_frame_slot_stack.sv @@
// ----------------------------------------------------------------------------
// scoped_frame_slot_stack
// Scoped allocator for frame slots over a stack of locals and scope markers.
//
// A request carries an opcode (allocate, push scope, pop), a slot size and an
// object flag; every request gives exactly one response with a status and a
// slot offset. Both channels use valid and stall.
// Allocate and push scope need no walk; a pop walks the stack one entry
// at a time, since each entry costs one read of the single entry memory.
// A request is taken at the first edge after the previous one has left
// the sequencer; its response then moves into the output register.
// While the receiver stalls, the response waits in the output register and
// one more request is taken and worked; its response waits in the sequencer
// and no further request is taken until it moves on.
// Reset (synchronous) leaves one scope marker on the stack and the frame
// offset at zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scoped_frame_slot_stack #(
   parameter int STACK_DEPTH = fsss_pkg::STACK_DEPTH_DEF,
   parameter int OFFSET_BITS = fsss_pkg::OFFSET_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fsss_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fsss_pkg::rsp_type rsp_payload
);

   import fsss_pkg::*;

   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int ENTRY_W = SLOT_W + OFFSET_BITS + 2;

   logic               res_valid;
   rsp_type            res_payload;
   logic               res_take;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic               rsp_valid_ff;
   rsp_type            rsp_payload_ff;

   fsss_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .OFFSET_BITS (OFFSET_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_payload (res_payload),
      .res_take    (res_take),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   fsss_mem #(
      .DEPTH   (STACK_DEPTH),
      .ENTRY_W (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_payload_ff <= res_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ tb/scoped_frame_slot_stack_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoped_frame_slot_stack_tb
// Self-checking bench for the scoped frame slot stack. Directed requests
// cover the field extremes, every opcode, offset overflow, a full stack, a
// pop on an empty stack and a pop that drains the stack. Segments of random
// requests follow, some biased toward growing or shrinking the stack, under
// several idle and stall mixes. Every response is checked against a local
// model of the stack and the frame offset.
// ----------------------------------------------------------------------------
module scoped_frame_slot_stack_tb;
   import fsss_pkg::*;

   localparam int          CLK_HALF     = 6;
   localparam int          DEPTH        = STACK_DEPTH_DEF;
   localparam int          OFFSET_LIMIT = (1 << OFFSET_BITS_DEF) - 1;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          HOLD_CYCLES  = 250;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // model of the slot stack
   logic [SLOT_W-1:0] slot_size_mem [DEPTH];
   logic [SLOT_W-1:0] slot_start_mem[DEPTH];
   logic              slot_obj_mem  [DEPTH];
   logic              slot_mark_mem [DEPTH];
   int                stack_count;
   logic [SLOT_W-1:0] frame_offset;

   rsp_type pending_rsps[$];
   int      error_count;
   int      send_idle_pct;
   int      stall_pct;
   int      hold_left;

   scoped_frame_slot_stack uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("Test completed with failures");
      $finish;
   end

   function automatic rsp_type predict_slot(input req_type item);
      rsp_type r;
      int      top;
      r.status      = STATUS_DONE;
      r.slot_offset = '0;
      case (item.opcode)
         OP_ALLOC: begin
            if (stack_count >= DEPTH ||
                int'(frame_offset) + int'(item.slot_size) > OFFSET_LIMIT) begin
               r.status = STATUS_FULL;
            end else begin
               slot_size_mem[stack_count]  = item.slot_size;
               slot_start_mem[stack_count] = frame_offset;
               slot_obj_mem[stack_count]   = item.is_object;
               slot_mark_mem[stack_count]  = 1'b0;
               stack_count++;
               r.slot_offset = frame_offset;
               frame_offset  = frame_offset + item.slot_size;
            end
         end
         OP_PUSH: begin
            if (stack_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               slot_size_mem[stack_count]  = '0;
               slot_start_mem[stack_count] = '0;
               slot_obj_mem[stack_count]   = 1'b0;
               slot_mark_mem[stack_count]  = 1'b1;
               stack_count++;
            end
         end
         OP_POP: begin
            r.status = STATUS_EMPTY;
            while (stack_count > 0) begin
               top = stack_count - 1;
               stack_count = top;
               if (slot_mark_mem[top]) begin
                  r.status = STATUS_MARKER;
                  break;
               end
               frame_offset = frame_offset - slot_size_mem[top];
               if (slot_obj_mem[top]) begin
                  r.status      = STATUS_OBJECT;
                  r.slot_offset = slot_start_mem[top];
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic req_type mk_req(input logic [1:0] op, input logic [SLOT_W-1:0] size,
                                      input logic obj);
      req_type r;
      r.opcode    = opcode_type'(op);
      r.slot_size = size;
      r.is_object = obj;
      return r;
   endfunction

   function automatic req_type rand_req(input mix_type mix);
      int         pick;
      int         size_pick;
      logic [1:0] op;
      logic [SLOT_W-1:0] size;
      pick = $urandom_range(99);
      if (pick < 5) begin
         return mk_req(2'($urandom()), 16'($urandom()), 1'($urandom()));
      end
      pick = $urandom_range(99);
      case (mix)
         MIX_GROW:   op = (pick < 55) ? OP_ALLOC : (pick < 85) ? OP_PUSH :
                          (pick < 97) ? OP_POP : OP_UNUSED;
         MIX_SHRINK: op = (pick < 20) ? OP_ALLOC : (pick < 30) ? OP_PUSH :
                          (pick < 97) ? OP_POP : OP_UNUSED;
         default:    op = (pick < 40) ? OP_ALLOC : (pick < 60) ? OP_PUSH :
                          (pick < 95) ? OP_POP : OP_UNUSED;
      endcase
      size_pick = $urandom_range(99);
      if (size_pick < 70)
         size = 16'($urandom_range(0, 63));
      else if (size_pick < 88)
         size = 16'($urandom_range(0, 4095));
      else
         size = 16'($urandom());
      return mk_req(op, size, 1'($urandom()));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_req(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsps.push_back(predict_slot(item));
   endtask

   task automatic wait_all_done();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // response check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_payload), 32'd0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.slot_offset !== want.slot_offset)
               report_mismatch("slot_offset", 32'(rsp_payload.slot_offset),
                               32'(want.slot_offset));
         end
      end
   end

   // receiver stall, with a counted hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_req(mk_req(OP_ALLOC, 16'd16, 1'b0));
      send_req(mk_req(OP_ALLOC, 16'd8, 1'b1));
      send_req(mk_req(OP_PUSH, 16'hffff, 1'b1));
      send_req(mk_req(OP_ALLOC, 16'hffff, 1'b0));
      send_req(mk_req(OP_ALLOC, 16'd4, 1'b0));
      send_req(mk_req(OP_POP, 16'hffff, 1'b1));
      send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_POP, 16'hffff, 1'b1));
      // drain: locals with no marker below them
      send_req(mk_req(OP_ALLOC, 16'd5, 1'b0));
      send_req(mk_req(OP_ALLOC, 16'd7, 1'b0));
      send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_UNUSED, 16'hffff, 1'b1));
      send_req(mk_req(OP_UNUSED, 16'h0000, 1'b0));
      send_req(mk_req(OP_ALLOC, 16'hffff, 1'b1));
      send_req(mk_req(OP_ALLOC, 16'd0, 1'b0));
      send_req(mk_req(OP_ALLOC, 16'd1, 1'b1));
      send_req(mk_req(OP_PUSH, 16'd0, 1'b0));
      send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_PUSH, 16'd0, 1'b0));
      wait_all_done();
   endtask

   task automatic test_stack_full();
      send_idle_pct = 26;
      stall_pct     = 26;
      while (stack_count < DEPTH)
         send_req(mk_req(OP_ALLOC, 16'($urandom_range(0, 3)), ($urandom_range(9) == 0)));
      send_req(mk_req(OP_ALLOC, 16'd0, 1'b0));
      send_req(mk_req(OP_PUSH, 16'd0, 1'b0));
      repeat (4) send_req(mk_req(OP_POP, 16'd0, 1'b0));
      send_req(mk_req(OP_PUSH, 16'd0, 1'b0));
      wait_all_done();
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      int      sent;
      int      seg_len;
      mix_type mix;
      send_idle_pct = idle;
      stall_pct     = stall;
      sent = 0;
      while (sent < count) begin
         mix = mix_type'($urandom_range(2));
         seg_len = $urandom_range(8, 40);
         repeat (seg_len) begin
            send_req(rand_req(mix));
            sent++;
         end
      end
      wait_all_done();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      @(negedge clock);
      hold_left = HOLD_CYCLES;
      repeat (30) send_req(rand_req(MIX_EVEN));
      wait_all_done();
   endtask

   task automatic test_drain_pause();
      send_idle_pct = 26;
      stall_pct     = 26;
      repeat (15) send_req(rand_req(MIX_GROW));
      wait_all_done();
      repeat (15) send_req(rand_req(MIX_SHRINK));
      wait_all_done();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_stall     = 1'b0;
      error_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 0;
      stack_count   = 1;
      frame_offset  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         slot_size_mem[i]  = '0;
         slot_start_mem[i] = '0;
         slot_obj_mem[i]   = 1'b0;
         slot_mark_mem[i]  = 1'b0;
      end
      slot_mark_mem[0] = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_stack_full();
      test_random(300, 0, 0);
      test_random(300, 78, 0);
      test_random(300, 0, 78);
      test_random(300, 26, 26);
      test_backpressure();
      test_drain_pause();

      if (pending_rsps.size() != 0)
         report_mismatch("missing responses", 32'd0, 32'(pending_rsps.size()));
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
